// File: hdl/unique_key_table_insert_delete_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unique key table
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_KEY_TABLE_INSERT_DELETE_DEFINES_SVH
`define UNIQUE_KEY_TABLE_INSERT_DELETE_DEFINES_SVH

// cond holds at every edge out of reset
`define UKT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define UKT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons holds in the cycle after ante
`define UKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ukt_pkg.sv
// ----------------------------------------------------------------------------
// ukt_pkg
// Field widths, register codes and request codes of the unique key table.
// ----------------------------------------------------------------------------
package ukt_pkg;

    localparam int KEY_W        = 64;
    localparam int IDX_W        = 4;
    localparam int CNT_OUT_W    = 5;
    localparam int FK_COUNT_W   = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int FACTORY_REGS = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FK_COUNT = 3'd0,
        CFG_FK_A     = 3'd1,
        CFG_FK_B     = 3'd2,
        CFG_FK_C     = 3'd3,
        CFG_FK_D     = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ACT_SAVE   = 1'b0,
        ACT_DELETE = 1'b1
    } action_t;

endpackage

// File: hdl/ukt_req_if.sv
// ----------------------------------------------------------------------------
// ukt_req_if
// Request channel: save a key or delete an entry.
// ----------------------------------------------------------------------------
interface ukt_req_if
    import ukt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             action;
    logic [KEY_W-1:0] key_value;
    logic [IDX_W-1:0] entry_index;

    modport source (output valid, output action, output key_value, output entry_index,
                    input ready);
    modport sink   (input valid, input action, input key_value, input entry_index,
                    output ready);
endinterface

// File: hdl/ukt_rsp_if.sv
// ----------------------------------------------------------------------------
// ukt_rsp_if
// Response channel: accepted flag and entry count after the request.
// ----------------------------------------------------------------------------
interface ukt_rsp_if
    import ukt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic [CNT_OUT_W-1:0] key_count;

    modport source (output valid, output accepted, output key_count, input ready);
    modport sink   (input valid, input accepted, input key_count, output ready);
endinterface

// File: hdl/ukt_cfg_if.sv
// ----------------------------------------------------------------------------
// ukt_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ukt_cfg_if
    import ukt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [KEY_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/ukt_key_mem.sv
// ----------------------------------------------------------------------------
// ukt_key_mem
// Key storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ukt_key_mem
    import ukt_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [KEY_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/ukt_cfg_regs.sv
// ----------------------------------------------------------------------------
// ukt_cfg_regs
// Factory key registers and the match of a key against the enabled ones.
// ----------------------------------------------------------------------------
module ukt_cfg_regs
    import ukt_pkg::*;
#(
    parameter int FACTORY_SLOTS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    ukt_cfg_if.sink          cfg,
    input  logic [KEY_W-1:0] key,
    output logic             factory_hit
);

    localparam int LIM = (FACTORY_SLOTS < FACTORY_REGS) ? FACTORY_SLOTS : FACTORY_REGS;

    logic [FK_COUNT_W-1:0] fk_count_reg;
    logic [KEY_W-1:0]      fk_reg [FACTORY_REGS];
    logic [FK_COUNT_W-1:0] fk_enabled;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fk_count_reg <= '0;
            for (int i = 0; i < FACTORY_REGS; i++)
            begin
                fk_reg[i] <= '0;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_FK_COUNT: fk_count_reg <= cfg.data[FK_COUNT_W-1:0];
                CFG_FK_A:     fk_reg[0]    <= cfg.data;
                CFG_FK_B:     fk_reg[1]    <= cfg.data;
                CFG_FK_C:     fk_reg[2]    <= cfg.data;
                CFG_FK_D:     fk_reg[3]    <= cfg.data;
                default:      ;
            endcase
        end
    end

    // saturate the count at the number of slots in use
    assign fk_enabled = (fk_count_reg > FK_COUNT_W'(LIM)) ? FK_COUNT_W'(LIM) : fk_count_reg;

    always_comb
    begin
        factory_hit = 1'b0;
        for (int i = 0; i < FACTORY_REGS; i++)
        begin
            if ((FK_COUNT_W'(i) < fk_enabled) && (fk_reg[i] == key))
            begin
                factory_hit = 1'b1;
            end
        end
    end

endmodule

// File: hdl/unique_key_table_insert_delete.sv
// ----------------------------------------------------------------------------
// unique_key_table_insert_delete
// Table of unique 64-bit keys with append on save and compaction on delete.
// ----------------------------------------------------------------------------
// Channels: req carries one request per beat (action 0 saves key_value,
// action 1 deletes the entry at entry_index); rsp returns one beat per
// request with the accepted flag and the entry count after it; cfg writes
// the factory key count (index 0) and factory keys a..d (indexes 1..4);
// the user must write cfg only while no request is in flight (the block
// does not enforce this). cfg is always ready. A request is taken only
// while the controller is idle. A save reads the stored keys one per cycle
// from the key memory, compares each against the new key and the enabled
// factory keys, and appends the new key only if none matched; a save to a
// full table is rejected. A delete moves each later entry down through the
// same key memory, one per cycle; a bad index is rejected. Reset empties
// the table at once (count to zero, no sweep) and clears the factory
// registers. A stalled rsp holds its beat; the next request is still taken
// and worked on, and its result waits until the beat is taken.
// ----------------------------------------------------------------------------
module unique_key_table_insert_delete
    import ukt_pkg::*;
#(
    parameter int MAX_KEYS      = 16,
    parameter int FACTORY_SLOTS = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    ukt_req_if.sink  req,
    ukt_rsp_if.source rsp,
    ukt_cfg_if.sink  cfg
);

`include "unique_key_table_insert_delete_defines.svh"

    localparam int ADDR_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int EXT_W  = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]     wr_cnt_reg, wr_cnt_next;
    logic                 pend_reg, pend_next;
    logic                 hit_reg, hit_next;
    logic                 ok_reg, ok_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_ok_reg, out_ok_next;
    logic [CNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;

    logic                 mem_wr_en;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [KEY_W-1:0]     mem_wr_data;
    logic                 mem_rd_en;
    logic [ADDR_W-1:0]    mem_rd_addr;
    logic [KEY_W-1:0]     mem_rd_data;

    logic                 factory_hit;
    logic                 rd_issue;
    logic                 work_done;
    logic [CMP_W-1:0]     idx_cmp;
    logic [CMP_W-1:0]     cnt_cmp;
    logic [EXT_W-1:0]     cnt_ext;

    ukt_key_mem #(
        .DEPTH  (MAX_KEYS),
        .ADDR_W (ADDR_W)
    ) u_key_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ukt_cfg_regs #(
        .FACTORY_SLOTS (FACTORY_SLOTS)
    ) u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .key         (key_reg),
        .factory_hit (factory_hit)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign rd_issue  = (rd_cnt_reg < count_reg);
    // all reads issued and the last read data consumed
    assign work_done = !rd_issue && !pend_reg;
    assign idx_cmp   = CMP_W'(req.entry_index);
    assign cnt_cmp   = CMP_W'(count_reg);
    assign cnt_ext   = EXT_W'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_cnt_next    = rd_cnt_reg;
        wr_cnt_next    = wr_cnt_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        ok_next        = ok_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_cnt_next   = out_cnt_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = wr_cnt_reg[ADDR_W-1:0];
        mem_wr_data    = mem_rd_data;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = rd_cnt_reg[ADDR_W-1:0];

        // drop the response beat once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    key_next  = req.key_value;
                    hit_next  = 1'b0;
                    pend_next = 1'b0;
                    if (req.action == ACT_SAVE)
                    begin
                        if (count_reg == CNT_W'(MAX_KEYS))
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            rd_cnt_next = '0;
                            state_next  = ST_SCAN;
                        end
                    end
                    else if (idx_cmp < cnt_cmp)
                    begin
                        wr_cnt_next = CNT_W'(idx_cmp);
                        rd_cnt_next = CNT_W'(idx_cmp) + CNT_W'(1);
                        state_next  = ST_SHIFT;
                    end
                    else
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                mem_rd_en = rd_issue;
                if (rd_issue)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                pend_next = rd_issue;
                if (pend_reg && (mem_rd_data == key_reg))
                begin
                    hit_next = 1'b1;
                end
                if (work_done)
                begin
                    if (!hit_reg && !factory_hit)
                    begin
                        // append at the end of the table
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_reg[ADDR_W-1:0];
                        mem_wr_data = key_reg;
                        count_next  = count_reg + CNT_W'(1);
                        ok_next     = 1'b1;
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_SHIFT:
            begin
                mem_rd_en = rd_issue;
                if (rd_issue)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                pend_next = rd_issue;
                // move the entry read last cycle down one place
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    wr_cnt_next = wr_cnt_reg + CNT_W'(1);
                end
                if (work_done)
                begin
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_cnt_next   = cnt_ext[CNT_OUT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            wr_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_cnt_reg    <= rd_cnt_next;
            wr_cnt_reg    <= wr_cnt_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        out_ok_reg  <= out_ok_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.accepted  = out_ok_reg;
    assign rsp.key_count = out_cnt_reg;

    `UKT_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(MAX_KEYS),
        "entry count above table size")
    `UKT_ASSERT_IMPL(a_wr_in_table, mem_wr_en, CNT_W'(mem_wr_addr) < count_next,
        "key memory write outside the table")
    `UKT_ASSERT_NEXT(a_finish_hold, state_reg == ST_FINISH && out_valid_reg && !rsp.ready,
        state_reg == ST_FINISH && out_valid_reg, "response overwritten while stalled")
    `UKT_ASSERT_NEXT(a_delete_shrink, state_reg == ST_SHIFT && work_done,
        count_reg == $past(count_reg) - CNT_W'(1), "delete did not shrink the table")

endmodule
